// File: src/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Mode codes, result kinds, the transaction group passed from the front
// to the back, and character constants.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_CAPACITY = 4096;
    localparam int CAP_W        = 13;
    localparam int LEN_W        = 12;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_FINISH,
        TERM_REJECT
    } term_t;

    // Results of one processing step: emitted bytes first, then an optional
    // terminating result. more is set when later steps of the same input
    // byte follow.
    typedef struct packed {
        logic [1:0]             n_emit;
        logic [2:0][7:0]        bytes;
        term_t                  term;
        logic [LEN_W-1:0]       base_len;
        logic                   more;
    } group_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;

endpackage

// File: src/jsu_queue.sv
// ---------------------------------------------------------------------------
// jsu_queue: short group queue between front and back
// Register based FIFO of processing groups with simultaneous push and pop.
// ---------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  group_t  wr_data,
    input  logic    rd_en,
    output group_t  rd_data,
    output logic    q_full,
    output logic    q_empty
);

    group_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_wr, do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/jsu_front.sv
// ---------------------------------------------------------------------------
// jsu_front: parser front end
// Accepts text bytes, runs the escape and hex parser one step per cycle
// while the queue is not full, replays pending hex characters at the end
// of the text, and hands the results of each step to the queue as one group.
// ---------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        text_byte,
    input  logic              first_of_text,
    input  logic              end_after,
    input  logic [CAP_W-1:0]  capacity,
    input  logic              q_full,
    output logic              in_full,
    output logic              grp_valid,
    output group_t            grp
);

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;

    localparam logic [7:0]  BYTE_NL    = 8'h0A;
    localparam logic [7:0]  BYTE_SPACE = 8'h20;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_2BYTE   = 16'h0080;
    localparam logic [15:0] CP_3BYTE   = 16'h0800;

    // Bit 4 flags a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= CH_0 && c <= CH_9)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
        begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    mode_t            mode_reg, mode_next;
    logic [2:0][7:0]  hex_reg, hex_next;
    logic [1:0]       seen_reg, seen_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             seq_reg, seq_next;
    logic [2:0][7:0]  rep_reg, rep_next;
    logic [1:0]       rep_n_reg, rep_n_next;
    logic [1:0]       idx_reg, idx_next;

    logic             seq_go, in_take, mode_live, in_op, op_valid, op_end, rep_more;
    logic [7:0]       op_char;
    logic [4:0]       h0, h1, h2, h3;
    logic [15:0]      cp;
    logic [CAP_W-1:0] cap_eff;
    logic [13:0]      base14, cap14, sum14;
    logic [LEN_W-1:0] base;
    logic             fits2, fits3;
    logic [1:0]       n_emit;
    logic [2:0][7:0]  emit_b;
    logic             fin, rej, chk;

    assign in_full   = seq_reg || q_full;
    assign seq_go    = seq_reg && !q_full;
    assign in_take   = push && !in_full;
    assign mode_live = (mode_reg == MODE_TEXT) || (mode_reg == MODE_ESC)
                       || (mode_reg == MODE_HEX);
    assign in_op     = in_take && !first_of_text && mode_live;
    assign op_valid  = seq_go || in_op;
    assign rep_more  = (idx_reg < rep_n_reg);
    assign op_end    = seq_go ? !rep_more : (text_byte == CH_NUL);
    assign op_char   = (seq_go && rep_more) ? rep_reg[idx_reg] : text_byte;

    assign cap_eff = (capacity > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : capacity;
    assign cap14   = {1'b0, cap_eff};
    assign base    = (in_take && first_of_text) ? '0 : count_reg;
    assign base14  = {2'b00, base};
    assign fits2   = (base14 + 14'd2) < cap14;
    assign fits3   = (base14 + 14'd3) < cap14;

    // Code point from the leading run of hex digits.
    assign h0 = hex_digit(hex_reg[0]);
    assign h1 = hex_digit(hex_reg[1]);
    assign h2 = hex_digit(hex_reg[2]);
    assign h3 = hex_digit(op_char);

    always_comb
    begin
        if (!h0[4])
        begin
            cp = 16'h0;
        end
        else if (!h1[4])
        begin
            cp = {12'h0, h0[3:0]};
        end
        else if (!h2[4])
        begin
            cp = {8'h0, h0[3:0], h1[3:0]};
        end
        else if (!h3[4])
        begin
            cp = {4'h0, h0[3:0], h1[3:0], h2[3:0]};
        end
        else
        begin
            cp = {h0[3:0], h1[3:0], h2[3:0], h3[3:0]};
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        hex_next   = hex_reg;
        seen_next  = seen_reg;
        seq_next   = seq_reg;
        rep_next   = rep_reg;
        rep_n_next = rep_n_reg;
        idx_next   = idx_reg;
        n_emit     = 2'd0;
        emit_b     = '0;
        fin        = 1'b0;
        rej        = 1'b0;
        chk        = 1'b0;

        if (in_take && first_of_text)
        begin
            seen_next = '0;
            hex_next  = '0;
            if (text_byte != CH_QUOTE)
            begin
                rej       = 1'b1;
                mode_next = MODE_DONE;
            end
            else
            begin
                mode_next = MODE_TEXT;
                if (!(14'd1 < cap14) || end_after)
                begin
                    fin = 1'b1;
                end
            end
        end
        else if (op_valid && op_end)
        begin
            unique case (mode_reg)
                MODE_TEXT:
                begin
                    fin = 1'b1;
                end
                MODE_ESC:
                begin
                    // A trailing backslash is kept as a literal.
                    n_emit    = 2'd1;
                    emit_b[0] = CH_BSLASH;
                    fin       = 1'b1;
                end
                MODE_HEX:
                begin
                    // Short hex escape: drop the u, replay what was collected.
                    mode_next  = MODE_TEXT;
                    seen_next  = '0;
                    rep_next   = hex_reg;
                    rep_n_next = seen_reg;
                    idx_next   = '0;
                    seq_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (op_valid)
        begin
            if (seq_go)
            begin
                idx_next = idx_reg + 1'b1;
            end
            unique case (mode_reg)
                MODE_TEXT:
                begin
                    if (op_char == CH_QUOTE)
                    begin
                        fin = 1'b1;
                    end
                    else if (op_char == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        n_emit    = 2'd1;
                        emit_b[0] = op_char;
                        chk       = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    if (op_char == CH_U)
                    begin
                        mode_next = MODE_HEX;
                        seen_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        n_emit    = 2'd1;
                        chk       = 1'b1;
                        if (op_char == CH_N)
                        begin
                            emit_b[0] = BYTE_NL;
                        end
                        else if (op_char == CH_T)
                        begin
                            emit_b[0] = BYTE_SPACE;
                        end
                        else
                        begin
                            emit_b[0] = op_char;
                        end
                    end
                end
                MODE_HEX:
                begin
                    if (seen_reg != 2'd3)
                    begin
                        hex_next[seen_reg] = op_char;
                        seen_next          = seen_reg + 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        seen_next = '0;
                        if (cp < CP_2BYTE)
                        begin
                            n_emit    = 2'd1;
                            emit_b[0] = cp[7:0];
                            chk       = 1'b1;
                        end
                        else if (cp < CP_3BYTE)
                        begin
                            if (fits2)
                            begin
                                n_emit    = 2'd2;
                                emit_b[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
                                emit_b[1] = UTF8_CONT | {2'b00, cp[5:0]};
                                chk       = 1'b1;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        else
                        begin
                            if (fits3)
                            begin
                                n_emit    = 2'd3;
                                emit_b[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                                emit_b[1] = UTF8_CONT | {2'b00, cp[11:6]};
                                emit_b[2] = UTF8_CONT | {2'b00, cp[5:0]};
                                chk       = 1'b1;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        sum14 = base14 + {12'b0, n_emit};
        if (chk && !((sum14 + 14'd1) < cap14))
        begin
            fin = 1'b1;
        end
        if (fin)
        begin
            mode_next = MODE_DONE;
        end

        // An end flag on a byte that did not finish the value schedules
        // an end step, which runs from the seq flag once the queue is not full.
        if (in_op && !op_end && end_after && !fin)
        begin
            seq_next   = 1'b1;
            rep_n_next = '0;
            idx_next   = '0;
        end
        if (fin)
        begin
            seq_next = 1'b0;
        end

        count_next = sum14[LEN_W-1:0];
    end

    always_comb
    begin
        grp.n_emit   = n_emit;
        grp.bytes    = emit_b;
        grp.term     = rej ? TERM_REJECT : (fin ? TERM_FINISH : TERM_NONE);
        grp.base_len = base;
        grp.more     = seq_next;
        grp_valid    = (n_emit != 2'd0) || fin || rej;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            hex_reg   <= '0;
            seen_reg  <= '0;
            count_reg <= '0;
            seq_reg   <= 1'b0;
            rep_n_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            hex_reg   <= hex_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            rep_n_reg <= rep_n_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_reg <= rep_next;
    end

endmodule

// File: src/jsu_back.sv
// ---------------------------------------------------------------------------
// jsu_back: result sequencer
// Walks the group at the head of the queue and presents its results one
// transaction at a time on the result side.
// ---------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  group_t            head,
    input  logic              head_valid,
    input  logic              pop,
    output logic              q_pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic [1:0]        kind,
    output logic [LEN_W-1:0]  out_length,
    output logic              last_in_run
);

    logic [1:0] sub_reg, sub_next;
    logic [2:0] total;
    logic       at_last, take;

    assign total   = {1'b0, head.n_emit} + {2'b00, (head.term != TERM_NONE)};
    assign at_last = ({1'b0, sub_reg} + 3'd1) == total;
    assign take    = pop && head_valid;
    assign q_pop   = take && at_last;
    assign empty   = !head_valid;

    always_comb
    begin
        if (sub_reg < head.n_emit)
        begin
            out_byte   = head.bytes[sub_reg];
            kind       = KIND_BYTE;
            out_length = head.base_len + {{(LEN_W-2){1'b0}}, sub_reg} + 1'b1;
        end
        else
        begin
            out_byte   = 8'h00;
            kind       = (head.term == TERM_REJECT) ? KIND_REJECT : KIND_FINISH;
            out_length = (head.term == TERM_REJECT) ? '0
                         : head.base_len + {{(LEN_W-2){1'b0}}, head.n_emit};
        end
        last_in_run = at_last && ((head.term != TERM_NONE) || !head.more);
        sub_next    = sub_reg;
        if (take)
        begin
            sub_next = at_last ? 2'd0 : sub_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= '0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

endmodule

// File: src/json_string_unescape_utf8.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string value unescaper with UTF-8 output
// Results of an accepted text byte can be popped in the following cycle at
// the earliest. Throughput: one text byte per cycle while full is low, set
// by the single-step parser in the front; the back delivers one result per
// cycle from the four-group queue while not empty. Ending the text holds the
// input while end steps and replayed hex characters run.
// Reset: parser idle, capacity 4096, queue empty; no clearing pass.
// ---------------------------------------------------------------------------
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        text_byte,
    input  logic              first_of_text,
    input  logic              end_after,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic [1:0]        kind,
    output logic [LEN_W-1:0]  out_length,
    output logic              last_in_run,
    input  logic              cfg_write_en,
    input  logic [CAP_W-1:0]  cfg_write_data
);

    // The output capacity counts the terminator of the software buffer, so
    // at most capacity minus one bytes are produced for each value.
    logic [CAP_W-1:0] capacity_reg;

    // Front to queue and queue to back.
    group_t grp_in;
    group_t grp_head;
    logic   grp_valid;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            capacity_reg <= cfg_write_data;
        end
    end

    // The front takes one transaction per cycle unless the queue is full or
    // it is busy with the end-of-text steps, which it runs on its own.
    jsu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .text_byte     (text_byte),
        .first_of_text (first_of_text),
        .end_after     (end_after),
        .capacity      (capacity_reg),
        .q_full        (q_full),
        .in_full       (full),
        .grp_valid     (grp_valid),
        .grp           (grp_in)
    );

    // Each queue entry holds all results of one parser step, so a hex escape
    // that yields three UTF-8 bytes takes a single entry.
    jsu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_valid),
        .wr_data (grp_in),
        .rd_en   (q_pop),
        .rd_data (grp_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // The back splits the head entry into single result transactions and
    // marks the last result caused by each text byte.
    jsu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (grp_head),
        .head_valid  (!q_empty),
        .pop         (pop),
        .q_pop       (q_pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .kind        (kind),
        .out_length  (out_length),
        .last_in_run (last_in_run)
    );

endmodule

// File: tb/sv/json_string_unescape_utf8_tb.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8_tb: self-checking testbench of the JSON unescaper
// Text bytes go in through the push/full queue side and decoded results come
// back through the empty/pop side. A cycle-free predictor in this file decodes
// every accepted byte and queues the results it expects. A checker compares
// every popped transaction field by field. Directed values come first, then
// random values under several capacity settings and idling patterns.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module json_string_unescape_utf8_tb
    import jsu_pkg::*;
();

    // At most this many results come out of one text byte.
    localparam int MAX_RESULTS = 4;
    // Cycles to let pass before a register write, so that a byte that
    // caused no result has certainly left the block (end step plus replay).
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any accepted transaction before the run is given up.
    localparam int STALL_LIMIT = 2000;

    typedef logic [7:0] text_q_t[$];

    // One decoded result as the block should present it.
    typedef struct {
        logic [7:0]       data;
        kind_t            kind;
        logic [LEN_W-1:0] length;
        logic             last;
    } unescaped_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       text_byte = 8'h00;
    logic             first_of_text = 1'b0;
    logic             end_after = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       out_byte;
    logic [1:0]       kind;
    logic [LEN_W-1:0] out_length;
    logic             last_in_run;
    logic             cfg_write_en = 1'b0;
    logic [CAP_W-1:0] cfg_write_data = '0;

    // Idling of the sender and of the receiver, in percent of cycles.
    int send_idle_pct = 15;
    int recv_idle_pct = 67;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Results that have been predicted and not yet popped, oldest first.
    unescaped_t unescaped_q[$];

    // Decoder state as the predictor tracks it.
    mode_t      parse_state = MODE_IDLE;
    logic [7:0] hex_held [3] = '{default: 8'h00};
    int         hex_count = 0;
    int         emitted = 0;
    int         capacity_reg = CAP_RESET;
    unescaped_t step_out[$];

    json_string_unescape_utf8 uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .text_byte      (text_byte),
        .first_of_text  (first_of_text),
        .end_after      (end_after),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .kind           (kind),
        .out_length     (out_length),
        .last_in_run    (last_in_run),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Records one result of the current byte. Results beyond the per-byte
    // maximum are dropped, the same way the block's group has no room.
    function automatic void add_result(input logic [7:0] b, input kind_t k);
        unescaped_t r;
        if (step_out.size() >= MAX_RESULTS)
            return;
        r.data   = b;
        r.kind   = k;
        r.length = (k == KIND_REJECT) ? '0 : emitted[LEN_W-1:0];
        r.last   = 1'b0;
        step_out.push_back(r);
    endfunction

    // True when k more bytes still leave room for the terminator. Values
    // above the maximum act as the maximum; zero behaves like one.
    function automatic bit has_room(input int k);
        int limit;
        limit = (capacity_reg > MAX_CAPACITY) ? MAX_CAPACITY : capacity_reg;
        return (emitted + k) < limit;
    endfunction

    function automatic void close_value();
        add_result(8'h00, KIND_FINISH);
        parse_state = MODE_DONE;
    endfunction

    function automatic void emit_byte(input int b);
        emitted++;
        add_result(b[7:0], KIND_BYTE);
    endfunction

    function automatic void stop_when_full();
        if (!has_room(1))
            close_value();
    endfunction

    // Value of one hex digit, or 16 when the character is not a digit.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return 16;
    endfunction

    // Handles one byte inside a value.
    function automatic void feed_char(input logic [7:0] c);
        logic [7:0] digits [4];
        int         cp;
        int         d;
        bit         stop;
        cp = 0;
        case (parse_state)
            MODE_TEXT:
            begin
                if (c == CH_QUOTE)
                    close_value();
                else if (c == CH_BSLASH)
                    parse_state = MODE_ESC;
                else
                begin
                    emit_byte(c);
                    stop_when_full();
                end
            end
            MODE_ESC:
            begin
                if (c == CH_U)
                begin
                    parse_state = MODE_HEX;
                    hex_count = 0;
                end
                else
                begin
                    parse_state = MODE_TEXT;
                    if (c == CH_N)
                        emit_byte('h0A);
                    else if (c == CH_T)
                        emit_byte('h20);
                    else
                        emit_byte(c);
                    stop_when_full();
                end
            end
            MODE_HEX:
            begin
                if (hex_count < 3)
                begin
                    hex_held[hex_count] = c;
                    hex_count++;
                end
                else
                begin
                    // Four characters are in; the leading hex digits make
                    // the code point and the first non-digit ends it.
                    digits = '{hex_held[0], hex_held[1], hex_held[2], c};
                    stop = 1'b0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (!stop)
                        begin
                            d = hex_value(digits[k]);
                            if (d > 15)
                                stop = 1'b1;
                            else
                                cp = (cp << 4) | d;
                        end
                    end
                    parse_state = MODE_TEXT;
                    hex_count = 0;
                    if (cp < 'h80)
                    begin
                        emit_byte(cp);
                        stop_when_full();
                    end
                    else if (cp < 'h800)
                    begin
                        if (!has_room(2))
                            close_value();
                        else
                        begin
                            emit_byte('hC0 | (cp >> 6));
                            emit_byte('h80 | (cp & 'h3F));
                            stop_when_full();
                        end
                    end
                    else
                    begin
                        if (!has_room(3))
                            close_value();
                        else
                        begin
                            emit_byte('hE0 | (cp >> 12));
                            emit_byte('h80 | ((cp >> 6) & 'h3F));
                            emit_byte('h80 | (cp & 'h3F));
                            stop_when_full();
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endfunction

    // End of the text inside a value. An open escape gives a backslash; an
    // unfinished unicode escape drops the u and replays the held characters
    // as ordinary text, and the end is then applied again.
    function automatic void text_ended();
        logic [7:0] pend [3];
        int         n;
        bit         again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (parse_state)
                MODE_TEXT:
                    close_value();
                MODE_ESC:
                begin
                    parse_state = MODE_TEXT;
                    emit_byte(CH_BSLASH);
                    stop_when_full();
                    if (parse_state != MODE_DONE)
                        close_value();
                end
                MODE_HEX:
                begin
                    n = (hex_count > 3) ? 3 : hex_count;
                    pend = hex_held;
                    parse_state = MODE_TEXT;
                    hex_count = 0;
                    for (int k = 0; k < n; k++)
                    begin
                        if (parse_state != MODE_DONE)
                            feed_char(pend[k]);
                    end
                    again = (parse_state != MODE_DONE);
                end
                default:
                    ;
            endcase
        end
    endfunction

    // Decodes one accepted text byte and queues the results it causes.
    function automatic void predict_item(input logic [7:0] b, input logic f, input logic e);
        step_out.delete();
        if (f)
        begin
            emitted = 0;
            hex_count = 0;
            hex_held = '{default: 8'h00};
            if (b != CH_QUOTE)
            begin
                add_result(8'h00, KIND_REJECT);
                parse_state = MODE_DONE;
            end
            else
            begin
                parse_state = MODE_TEXT;
                stop_when_full();
                if (parse_state != MODE_DONE && e)
                    close_value();
            end
        end
        else if (parse_state != MODE_IDLE && parse_state != MODE_DONE)
        begin
            // A zero byte is the terminator itself.
            if (b == CH_NUL)
                text_ended();
            else
            begin
                feed_char(b);
                if (e && parse_state != MODE_DONE)
                    text_ended();
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            unescaped_q.push_back(step_out[i]);
    endfunction

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------

    // Offers one text byte after a random gap and waits for the edge that
    // accepts it. push stays high when the next byte follows at once.
    task automatic send_item(input logic [7:0] b, input logic f, input logic e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        text_byte     <= b;
        first_of_text <= f;
        end_after     <= e;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(b, f, e);
    endtask

    // Sends a whole value; the first byte starts it, and the last byte may
    // carry the end of the text.
    task automatic send_value(input text_q_t chars, input logic end_last);
        foreach (chars[i])
            send_item(chars[i], i == 0, end_last && (i == chars.size() - 1));
    endtask

    // Writes the capacity once every expected result is out and any byte
    // that caused none has had time to leave the block.
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        push <= 1'b0;
        while (unescaped_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        capacity_reg = value;
    endtask

    function automatic logic [7:0] hex_char(input int d);
        if (d < 10)
            return 8'(d + 'h30);
        return 8'(($urandom_range(1) ? 'h61 : 'h41) + d - 10);
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // A first byte that is not a quote, a stray byte after it, a quote that
    // is also the end of the text, and a stray zero with end after that.
    task automatic test_reject_and_ignore();
        send_item("x", 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(CH_QUOTE, 1'b1, 1'b1);
        send_item(CH_NUL, 1'b0, 1'b1);
    endtask

    // Plain top byte, newline and tab escapes, an escaped quote, a surrogate
    // code point, hex parsing that stops at a non-digit, and a backslash as
    // the last byte of the text.
    task automatic test_escapes();
        send_value({CH_QUOTE, 8'hFF, CH_BSLASH, CH_N, CH_BSLASH, CH_T,
                    CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_U, "D", "8", "0", "0",
                    CH_BSLASH, CH_U, "7", "g", "z", "z", CH_BSLASH}, 1'b1);
    endtask

    // A unicode escape cut short by the zero terminator: the held digits
    // come out as plain text.
    task automatic test_short_hex();
        send_value({CH_QUOTE, CH_BSLASH, CH_U, "0", "e", CH_NUL}, 1'b0);
    endtask

    // A two-byte sequence that does not fit, and a capacity that finishes
    // every value at once.
    task automatic test_capacity_limits();
        set_capacity(13'd2);
        send_value({CH_QUOTE, CH_BSLASH, CH_U, "0", "0", "e", "9"}, 1'b0);
        set_capacity(13'd1);
        send_value({CH_QUOTE, "a"}, 1'b0);
    endtask

    // Random values: mostly well-formed strings with random content and
    // random endings, with some rejects, stray bytes and abandoned values.
    task automatic test_random_values(input int send_pct, input int recv_pct,
                                      input logic [CAP_W-1:0] capacity,
                                      input int n_items);
        text_q_t     chars;
        logic        end_last;
        int          sent;
        int          pick;
        int          n_digits;
        int          bad_pos;
        logic [15:0] cp;
        logic [7:0]  c;
        set_capacity(capacity);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                c = 8'($urandom);
                if (pick < 5)
                    send_item(c, 1'b0, 1'($urandom_range(1)));
                else
                begin
                    if (c == CH_QUOTE)
                        c = 8'h27;
                    send_item(c, 1'b1, 1'($urandom_range(1)));
                    sent++;
                end
                continue;
            end
            chars = {CH_QUOTE};
            repeat ($urandom_range(6))
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                begin
                    c = 8'($urandom_range(1, 255));
                    if (c == CH_QUOTE || c == CH_BSLASH)
                        c = c ^ 8'h01;
                    chars.push_back(c);
                end
                else if (pick < 65)
                begin
                    case ($urandom_range(5))
                        0: c = CH_N;
                        1: c = CH_T;
                        2: c = CH_QUOTE;
                        3: c = CH_BSLASH;
                        4: c = "/";
                        default:
                        begin
                            c = 8'($urandom);
                            if (c == CH_U)
                                c = CH_N;
                        end
                    endcase
                    chars.push_back(CH_BSLASH);
                    chars.push_back(c);
                end
                else
                begin
                    // Pick the code point so that one, two and three byte
                    // encodings all come up often.
                    case ($urandom_range(2))
                        0: cp = 16'($urandom_range(16'h007F));
                        1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
                        default: cp = 16'($urandom);
                    endcase
                    bad_pos = ($urandom_range(9) == 0) ? $urandom_range(3) : 4;
                    chars.push_back(CH_BSLASH);
                    chars.push_back(CH_U);
                    for (int k = 0; k < 4; k++)
                    begin
                        if (k == bad_pos)
                            chars.push_back($urandom_range(1) ? 8'h67 : 8'($urandom));
                        else
                            chars.push_back(hex_char(cp[15 - 4 * k -: 4]));
                    end
                end
            end
            // How the value ends.
            end_last = 1'b0;
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                chars.push_back(CH_QUOTE);
                end_last = 1'($urandom_range(1));
            end
            else if (pick < 55)
                end_last = 1'b1;
            else if (pick < 65)
                chars.push_back(CH_NUL);
            else if (pick < 80)
            begin
                // Unicode escape cut short by the end of the text.
                chars.push_back(CH_BSLASH);
                chars.push_back(CH_U);
                n_digits = $urandom_range(3);
                repeat (n_digits)
                    chars.push_back(($urandom_range(4) == 0)
                                    ? 8'($urandom_range(1, 255))
                                    : hex_char($urandom_range(15)));
                if ($urandom_range(1))
                    end_last = 1'b1;
                else
                    chars.push_back(CH_NUL);
            end
            else if (pick < 88)
            begin
                chars.push_back(CH_BSLASH);
                end_last = 1'b1;
            end
            // Otherwise the value is left open and the next one restarts.
            send_value(chars, end_last);
            sent += chars.size();
            if ($urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'($urandom_range(1)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Receiver and checker
    // -----------------------------------------------------------------------

    // Each popped transaction is compared with the oldest prediction. pop is
    // redrawn every cycle so that stalls fall anywhere in the stream.
    always @(posedge clk)
    begin
        unescaped_t want;
        if (rst_n && pop && !empty)
        begin
            if (unescaped_q.size() == 0)
            begin
                $error("unexpected result: out_byte %0h kind %0d out_length %0d",
                       out_byte, kind, out_length);
                mismatch_count++;
            end
            else
            begin
                want = unescaped_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte expected %0h actual %0h", want.data, out_byte);
                    mismatch_count++;
                end
                if (kind !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, kind);
                    mismatch_count++;
                end
                if (out_length !== want.length)
                begin
                    $error("out_length expected %0d actual %0d", want.length, out_length);
                    mismatch_count++;
                end
                if (last_in_run !== want.last)
                begin
                    $error("last_in_run expected %0d actual %0d", want.last, last_in_run);
                    mismatch_count++;
                end
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a long stretch with no accepted transaction on either side
    // means the block hangs or a result never came.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("json_string_unescape_utf8 test failed");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence of the run
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the sender idling lightly and the receiver
        // stalling often.
        test_reject_and_ignore();
        test_escapes();
        test_short_hex();
        test_capacity_limits();

        // Random part: first the receiver stalls most, then the sender
        // idles most, then both run flat out.
        test_random_values(15, 67, 13'd3, 30);
        test_random_values(15, 67, 13'd8191, 30);
        test_random_values(67, 15, 13'd0, 15);
        test_random_values(67, 15, 13'd5, 30);
        test_random_values(0, 0, 13'd4096, 40);
        test_random_values(0, 0, 13'd12, 35);

        push <= 1'b0;
        while (unescaped_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("json_string_unescape_utf8 test passed");
        else
            $display("json_string_unescape_utf8 test failed");
        $finish;
    end

endmodule
